// File: src/sipf_pkg.sv
// Shared types, opcodes and protocol constants for the servo instruction packet framer.
// No dependencies; every other file but the checker refers to this package by scoped names.
package sipf_pkg;

    localparam int unsigned SIPF_FRAME_BYTES = 16;
    localparam int unsigned SIPF_IDX_W       = $clog2(SIPF_FRAME_BYTES);

    localparam logic [5:0] SIPF_MAX_SYNC = 6'd32;

    // Command operation codes
    localparam logic [2:0] OP_PING      = 3'd0;
    localparam logic [2:0] OP_READ      = 3'd1;
    localparam logic [2:0] OP_WRITE     = 3'd2;
    localparam logic [2:0] OP_REG_WRITE = 3'd3;
    localparam logic [2:0] OP_ACTION    = 3'd4;
    localparam logic [2:0] OP_RESET     = 3'd5;
    localparam logic [2:0] OP_SYNC      = 3'd6;
    localparam logic [2:0] OP_UNUSED    = 3'd7;

    // Instruction bytes on the line
    localparam logic [7:0] INST_PING      = 8'h01;
    localparam logic [7:0] INST_READ      = 8'h02;
    localparam logic [7:0] INST_WRITE     = 8'h03;
    localparam logic [7:0] INST_REG_WRITE = 8'h04;
    localparam logic [7:0] INST_ACTION    = 8'h05;
    localparam logic [7:0] INST_RESET     = 8'h06;
    localparam logic [7:0] INST_SYNC      = 8'h83;

    localparam logic [7:0] PKT_HEADER    = 8'hFF;
    localparam logic [7:0] ID_BROADCAST  = 8'hFE;
    localparam logic [7:0] LEN_NO_PARAM  = 8'h02;
    localparam logic [7:0] LEN_TWO_PARAM = 8'h04;
    localparam logic [7:0] READ_ONE_BYTE = 8'h01;

    typedef struct packed {
        logic [7:0] sum;
        logic       active;
        logic       wide;
        logic [5:0] left;
    } t_sync_state;

    typedef struct packed {
        logic [SIPF_FRAME_BYTES-1:0][7:0] bytes;
        logic [SIPF_FRAME_BYTES-1:0]      eop;
        logic [SIPF_IDX_W-1:0]            last_idx;
        logic                             nonempty;
    } t_frame;

endpackage

// File: src/sipf_encode.sv
// Turns one command plus the sync-write state into a frame of up to sixteen line bytes.
// Pure combinational; uses sipf_pkg types and constants.
module sipf_encode (
    input  logic [2:0]           i_operation,
    input  logic [7:0]           i_servo_id,
    input  logic [7:0]           i_address,
    input  logic [15:0]          i_data,
    input  logic                 i_two_bytes,
    input  logic [5:0]           i_entry_count,
    input  logic                 i_first_entry,
    input  sipf_pkg::t_sync_state i_state,
    output sipf_pkg::t_frame      o_frame,
    output sipf_pkg::t_sync_state o_state_next
);

    // Eight-byte packet with two parameters
    function automatic logic [7:0][7:0] pkt8(input logic [7:0] id, input logic [7:0] inst,
                                             input logic [7:0] a, input logic [7:0] p);
        logic [7:0][7:0] b;
        logic [7:0]      sum;
        sum  = id + sipf_pkg::LEN_TWO_PARAM + inst + a + p;
        b[0] = sipf_pkg::PKT_HEADER;
        b[1] = sipf_pkg::PKT_HEADER;
        b[2] = id;
        b[3] = sipf_pkg::LEN_TWO_PARAM;
        b[4] = inst;
        b[5] = a;
        b[6] = p;
        b[7] = ~sum;
        return b;
    endfunction

    // Six-byte packet with no parameters
    function automatic logic [5:0][7:0] pkt6(input logic [7:0] id, input logic [7:0] inst);
        logic [5:0][7:0] b;
        logic [7:0]      sum;
        sum  = id + sipf_pkg::LEN_NO_PARAM + inst;
        b[0] = sipf_pkg::PKT_HEADER;
        b[1] = sipf_pkg::PKT_HEADER;
        b[2] = id;
        b[3] = sipf_pkg::LEN_NO_PARAM;
        b[4] = inst;
        b[5] = ~sum;
        return b;
    endfunction

    always_comb begin
        logic [7:0]                      inst;
        logic [7:0]                      addr_hi;
        logic [7:0]                      p_lo;
        logic [7:0]                      p_hi;
        logic                            wide;
        logic [5:0]                      cnt_sat;
        logic [7:0]                      cnt8;
        logic [7:0]                      lbytes;
        logic [7:0]                      len;
        logic [5:0]                      el;
        logic [5:0]                      el_next;
        logic                            done;
        logic [7:0]                      s;
        logic [sipf_pkg::SIPF_IDX_W-1:0] idx;

        o_frame      = '0;
        o_state_next = i_state;
        inst         = sipf_pkg::INST_PING;
        addr_hi      = i_address + 8'd1;
        p_lo         = i_data[7:0];
        p_hi         = i_data[15:8];
        wide         = i_first_entry ? i_two_bytes : i_state.wide;
        lbytes       = i_two_bytes ? 8'd2 : 8'd1;

        // Saturate the entry count into 1..max
        if (i_entry_count == 6'd0) begin
            cnt_sat = 6'd1;
        end else if (i_entry_count > sipf_pkg::SIPF_MAX_SYNC) begin
            cnt_sat = sipf_pkg::SIPF_MAX_SYNC;
        end else begin
            cnt_sat = i_entry_count;
        end
        cnt8    = {2'b00, cnt_sat};
        len     = 8'd4 + (i_two_bytes ? cnt8 * 8'd3 : cnt8 * 8'd2);
        el      = i_first_entry ? cnt_sat : i_state.left;
        el_next = el - 6'd1;
        done    = (el_next == 6'd0);
        s       = i_first_entry
                ? sipf_pkg::ID_BROADCAST + len + sipf_pkg::INST_SYNC + i_address + lbytes
                : i_state.sum;
        s       = s + i_servo_id + i_data[7:0] + (wide ? i_data[15:8] : 8'd0);
        idx     = '0;

        unique case (i_operation)
            sipf_pkg::OP_SYNC: begin
                if (i_first_entry || i_state.active) begin
                    o_frame.nonempty = 1'b1;
                    if (i_first_entry) begin
                        o_frame.bytes[0] = sipf_pkg::PKT_HEADER;
                        o_frame.bytes[1] = sipf_pkg::PKT_HEADER;
                        o_frame.bytes[2] = sipf_pkg::ID_BROADCAST;
                        o_frame.bytes[3] = len;
                        o_frame.bytes[4] = sipf_pkg::INST_SYNC;
                        o_frame.bytes[5] = i_address;
                        o_frame.bytes[6] = lbytes;
                        idx              = sipf_pkg::SIPF_IDX_W'(7);
                    end
                    o_frame.bytes[idx] = i_servo_id;
                    idx                = idx + 1'b1;
                    o_frame.bytes[idx] = i_data[7:0];
                    if (wide) begin
                        idx                = idx + 1'b1;
                        o_frame.bytes[idx] = i_data[15:8];
                    end
                    if (done) begin
                        idx                = idx + 1'b1;
                        o_frame.bytes[idx] = ~s;
                        o_frame.eop[idx]   = 1'b1;
                    end
                    o_frame.last_idx    = idx;
                    o_state_next.active = !done;
                    o_state_next.wide   = wide;
                    o_state_next.left   = el_next;
                    o_state_next.sum    = done ? 8'd0 : s;
                end
            end
            sipf_pkg::OP_UNUSED: begin
                // drop: no bytes, state kept
            end
            default: begin
                // Any other command abandons an open sync run
                o_state_next.active = 1'b0;
                o_state_next.left   = 6'd0;
                o_state_next.sum    = 8'd0;
                o_frame.nonempty    = 1'b1;
                unique case (i_operation)
                    sipf_pkg::OP_READ:      inst = sipf_pkg::INST_READ;
                    sipf_pkg::OP_WRITE:     inst = sipf_pkg::INST_WRITE;
                    sipf_pkg::OP_REG_WRITE: inst = sipf_pkg::INST_REG_WRITE;
                    sipf_pkg::OP_ACTION:    inst = sipf_pkg::INST_ACTION;
                    sipf_pkg::OP_RESET:     inst = sipf_pkg::INST_RESET;
                    default:                inst = sipf_pkg::INST_PING;
                endcase
                if (i_operation == sipf_pkg::OP_READ) begin
                    p_lo = sipf_pkg::READ_ONE_BYTE;
                    p_hi = sipf_pkg::READ_ONE_BYTE;
                end
                if (i_operation == sipf_pkg::OP_READ || i_operation == sipf_pkg::OP_WRITE
                    || i_operation == sipf_pkg::OP_REG_WRITE) begin
                    o_frame.bytes[7:0] = pkt8(i_servo_id, inst, i_address, p_lo);
                    o_frame.eop[7]     = 1'b1;
                    o_frame.last_idx   = sipf_pkg::SIPF_IDX_W'(7);
                    if (i_two_bytes) begin
                        o_frame.bytes[15:8] = pkt8(i_servo_id, inst, addr_hi, p_hi);
                        o_frame.eop[15]     = 1'b1;
                        o_frame.last_idx    = sipf_pkg::SIPF_IDX_W'(15);
                    end
                end else begin
                    o_frame.bytes[5:0] = pkt6(i_servo_id, inst);
                    o_frame.eop[5]     = 1'b1;
                    o_frame.last_idx   = sipf_pkg::SIPF_IDX_W'(5);
                end
            end
        endcase
    end

endmodule

// File: src/sipf_serializer.sv
// Holds one encoded frame and shifts its bytes, one per cycle while the output is not
// stalled, into the output register. Uses sipf_pkg::t_frame.
module sipf_serializer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  sipf_pkg::t_frame i_frame,
    input  logic             i_out_ready,
    output logic             o_take,
    output logic             o_valid,
    output logic [7:0]       o_tx_byte,
    output logic             o_end_of_packet,
    output logic             o_last
);

    logic                            r_busy;
    logic [sipf_pkg::SIPF_IDX_W-1:0] r_idx;
    sipf_pkg::t_frame                r_frame;
    logic                            r_out_valid;
    logic [7:0]                      r_tx_byte;
    logic                            r_eop;
    logic                            r_last;

    logic can_out;
    logic emit;
    logic at_end;

    assign can_out = !r_out_valid || i_out_ready;
    assign emit    = r_busy && can_out;
    assign at_end  = (r_idx == r_frame.last_idx);
    // Take the next request while the final byte of this one moves out
    assign o_take  = !r_busy || (emit && at_end);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_load) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (emit && at_end) begin
                r_busy <= 1'b0;
            end else if (emit) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_frame <= i_frame;
        end
        if (emit) begin
            r_tx_byte <= r_frame.bytes[r_idx];
            r_eop     <= r_frame.eop[r_idx];
            r_last    <= at_end;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_tx_byte       = r_tx_byte;
    assign o_end_of_packet = r_eop;
    assign o_last          = r_last;

endmodule

// File: src/servo_instruction_packet_framer.sv
// Top level of the servo instruction packet framer: sync-write state, encoder and serializer.
// Depends on sipf_pkg, sipf_encode and sipf_serializer.

// Each accepted command leaves as the bytes of its instruction packet(s), one byte per
// cycle on the output channel while it is not stalled: 6 bytes for ping, action and
// factory reset, 8 for read, write and deferred write, 16 when those are 16-bit, and 2 to
// 11 for a sync-write entry (header bytes on the first entry, checksum on the last). The
// byte serializer sets the rate; the next command is taken in the cycle its predecessor's
// last byte moves into the output register, so back-to-back commands leave no gap on the
// line. Opcode 7 and a sync entry with no run open are taken and produce nothing. o_last
// marks the final byte of each command, o_end_of_packet each checksum byte.
module servo_instruction_packet_framer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_operation,
    input  logic [7:0]  i_servo_id,
    input  logic [7:0]  i_address,
    input  logic [15:0] i_data,
    input  logic        i_two_bytes,
    input  logic [5:0]  i_entry_count,
    input  logic        i_first_entry,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_tx_byte,
    output logic        o_end_of_packet,
    output logic        o_last
);

    sipf_pkg::t_sync_state r_state;
    sipf_pkg::t_sync_state n_state;
    sipf_pkg::t_frame      frame;
    logic                  accept;
    logic                  take;

    sipf_encode u_encode (
        .i_operation   (i_operation),
        .i_servo_id    (i_servo_id),
        .i_address     (i_address),
        .i_data        (i_data),
        .i_two_bytes   (i_two_bytes),
        .i_entry_count (i_entry_count),
        .i_first_entry (i_first_entry),
        .i_state       (r_state),
        .o_frame       (frame),
        .o_state_next  (n_state)
    );

    assign accept  = i_valid && take;
    assign o_ready = take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    sipf_serializer u_serializer (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (accept && frame.nonempty),
        .i_frame         (frame),
        .i_out_ready     (i_ready),
        .o_take          (take),
        .o_valid         (o_valid),
        .o_tx_byte       (o_tx_byte),
        .o_end_of_packet (o_end_of_packet),
        .o_last          (o_last)
    );

endmodule

// File: src/sipf_checker.sv
// Port-level assertions for the servo instruction packet framer, bound to the top level.
// Sees only the top-level ports; no package dependency.
module sipf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [7:0]  o_tx_byte,
    input logic        o_end_of_packet,
    input logic        o_last
);

    // Hold a stalled output byte
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_tx_byte)
            && $stable(o_end_of_packet) && $stable(o_last))
        else $error("output byte changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    // A request's bytes leave without gaps: a taken non-final byte is followed by another
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last |=> o_valid)
        else $error("gap inside the bytes of one request");

endmodule

bind servo_instruction_packet_framer sipf_checker u_sipf_checker (.*);
